// File: rtl/core/rc4sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rc4sc_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned SBOX_AW  = 8;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned PADDR_W  = 4;

    localparam logic [KEY_W-1:0] KEY_LOW_RST  = 64'h0709_0555_0403_4E7C;
    localparam logic [KEY_W-1:0] KEY_HIGH_RST = 64'h1117_0D17_387B_2C2D;

    // paddr[3] selects the register (byte addresses 0 and 8)
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_FILL      = 10'b00_0000_0010,
        ST_KS_RD_N   = 10'b00_0000_0100,
        ST_KS_RD_ACC = 10'b00_0000_1000,
        ST_KS_WR_N   = 10'b00_0001_0000,
        ST_KS_WR_ACC = 10'b00_0010_0000,
        ST_RD_I      = 10'b00_0100_0000,
        ST_RD_J      = 10'b00_1000_0000,
        ST_WR_I      = 10'b01_0000_0000,
        ST_WR_J      = 10'b10_0000_0000
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/rc4_stream_cipher.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Transfer on                       Carries
// ------    --------------------------------  ---------------------------------
// in        in_valid & in_ready               data_in, start_of_buffer
// out       out_valid & out_ready             data_out
// apb       psel & penable & pwrite & pready  pwdata -> key_low / key_high
//
// A keyed byte goes from transfer to result through read S[i], read S[j],
// write S[i], write S[j]; the single write port of the S-box sets this order.
// A key schedule adds 256 fill writes, then one swap for each index of S.
// The schedule runs on start_of_buffer, and on the first byte after reset.
// in_ready is high only in idle; a full output register holds the last step.

module rc4_stream_cipher
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [rc4sc_pkg::DATA_W-1:0] data_in,
    input  wire                          start_of_buffer,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [rc4sc_pkg::DATA_W-1:0] data_out,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [rc4sc_pkg::PADDR_W-1:0] paddr,
    input  wire  [rc4sc_pkg::KEY_W-1:0]  pwdata,
    output logic [rc4sc_pkg::KEY_W-1:0]  prdata,
    output logic                         pready
);

    import rc4sc_pkg::*;

    state_t               state_reg, state_next;
    logic [SBOX_AW-1:0]   cnt_reg, cnt_next;
    logic [DATA_W-1:0]    acc_reg, acc_next;
    logic [DATA_W-1:0]    i_reg, i_next;
    logic [DATA_W-1:0]    j_reg, j_next;
    logic [DATA_W-1:0]    a_reg, a_next;
    logic [DATA_W-1:0]    b_reg, b_next;
    logic [DATA_W-1:0]    t_reg, t_next;
    logic [DATA_W-1:0]    byte_reg, byte_next;
    logic                 keyed_reg, keyed_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    data_out_reg, data_out_next;
    logic [KEY_W-1:0]     key_low_reg, key_low_next;
    logic [KEY_W-1:0]     key_high_reg, key_high_next;

    logic [DATA_W-1:0]    sbox_mem [2**SBOX_AW];
    logic                 mem_we, mem_re;
    logic [SBOX_AW-1:0]   mem_waddr, mem_raddr;
    logic [DATA_W-1:0]    mem_wdata, mem_rdata;

    logic [2*KEY_W-1:0]   key_all;
    logic [DATA_W-1:0]    key_byte;
    logic [DATA_W-1:0]    ks;
    logic                 out_free;
    logic                 cfg_wr;

    assign key_all  = {key_high_reg, key_low_reg};
    assign key_byte = key_all[{cnt_reg[3:0], 3'b000} +: DATA_W];
    assign out_free = !out_valid_reg || out_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[3] == REG_KEY_HIGH) ? key_high_reg : key_low_reg;

    // swap order is S[i]=b then S[j]=a, so a hit on j wins
    always_comb
    begin
        if (t_reg == j_reg)
            ks = a_reg;
        else if (t_reg == i_reg)
            ks = b_reg;
        else
            ks = mem_rdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            sbox_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata <= sbox_mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        t_next         = t_reg;
        byte_next      = byte_reg;
        keyed_next     = keyed_reg;
        out_valid_next = out_valid_reg;
        data_out_next  = data_out_reg;
        key_low_next   = key_low_reg;
        key_high_next  = key_high_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = cnt_reg;
        mem_raddr      = cnt_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cfg_wr)
        begin
            if (paddr[3] == REG_KEY_HIGH)
                key_high_next = pwdata;
            else
                key_low_next = pwdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = data_in;
                    if (start_of_buffer || !keyed_reg)
                    begin
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end
                    else
                        state_next = ST_RD_I;
                end
            end
            ST_FILL:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    acc_next   = '0;
                    state_next = ST_KS_RD_N;
                end
            end
            ST_KS_RD_N:
            begin
                mem_re     = 1'b1;
                state_next = ST_KS_RD_ACC;
            end
            ST_KS_RD_ACC:
            begin
                a_next     = mem_rdata;
                acc_next   = acc_reg + mem_rdata + key_byte;
                mem_re     = 1'b1;
                mem_raddr  = acc_next;
                state_next = ST_KS_WR_N;
            end
            ST_KS_WR_N:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                state_next = ST_KS_WR_ACC;
            end
            ST_KS_WR_ACC:
            begin
                mem_we    = 1'b1;
                mem_waddr = acc_reg;
                mem_wdata = a_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = ST_RD_I;
                end
                else
                    state_next = ST_KS_RD_N;
            end
            ST_RD_I:
            begin
                i_next     = i_reg + 1'b1;
                mem_re     = 1'b1;
                mem_raddr  = i_next;
                state_next = ST_RD_J;
            end
            ST_RD_J:
            begin
                a_next     = mem_rdata;
                j_next     = j_reg + mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = j_next;
                state_next = ST_WR_I;
            end
            ST_WR_I:
            begin
                b_next     = mem_rdata;
                mem_we     = 1'b1;
                mem_waddr  = i_reg;
                mem_wdata  = mem_rdata;
                t_next     = a_reg + mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = t_next;
                state_next = ST_WR_J;
            end
            ST_WR_J:
            begin
                // rewrite while stalled is harmless, read data holds
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = a_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    data_out_next  = byte_reg ^ ks;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            key_low_reg   <= KEY_LOW_RST;
            key_high_reg  <= KEY_HIGH_RST;
            i_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        t_reg        <= t_next;
        byte_reg     <= byte_next;
        data_out_reg <= data_out_next;
    end

    a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        keyed_reg |=> keyed_reg)
        else $error("keyed flag dropped");

    a_stream_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_I) |-> keyed_reg)
        else $error("stream step on unkeyed S-box");

    a_out_from_wrj: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WR_J))
        else $error("result without a finished byte");

    a_swap_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KS_RD_N && $past(state_reg == ST_FILL)) |->
            (cnt_reg == '0 && acc_reg == '0))
        else $error("key schedule did not start at zero");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(data_out_reg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
